FILE: hw/rtl/mpool_pkg.sv
// Shared types, constants and register codes for the multichannel 1-D max pooling block.
`default_nettype none

package mpool_pkg;

  // Sizing defaults for the top level parameters.
  localparam int MAX_WINDOW_DEF   = 16;
  localparam int MAX_CHANNELS_DEF = 256;

  // Fixed field widths.
  localparam int SAMPLE_BITS = 16;
  localparam int ROW_W       = 16;
  localparam int CHAN_OUT_W  = 8;
  localparam int PAD_W       = 4;
  localparam int STEP_W      = 5;
  localparam int WSIZE_W     = 5;
  localparam int NCH_CFG_W   = 9;
  localparam int E_W         = PAD_W + 2;
  localparam int MAX_RESULTS = 16;
  localparam int N_W         = $clog2(MAX_RESULTS + 1);

  // Configuration port.
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_ROWS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_ROWS      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          row_end;
    logic                          sequence_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] pooled;
    logic [ROW_W-1:0]              out_row_index;
    logic [CHAN_OUT_W-1:0]         out_channel_index;
    logic                          run_last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } ctl_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;     // take the request, write history
    logic win_start;  // open a window maximum
    logic scan;       // read one window row
    logic emit_load;  // load the result register
    logic e_done;     // close one window position
    logic fired;      // that position ended a window
    logic finish;     // close the request, update row state
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic w_zero;
    logic cap;
    logic e_last;
    logic scan_last;
    logic out_free;
  } ctl_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mpool_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module mpool_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/mpool_ctrl.sv
// Sequencer state machine for the max pooling block.
`default_nettype none

module mpool_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire mpool_pkg::ctl_sts_t sts,
  output      mpool_pkg::ctl_cmd_t cmd
);

  mpool_pkg::ctl_state_t state_r;
  mpool_pkg::ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpool_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mpool_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = mpool_pkg::ST_STEP;
        end
      end
      mpool_pkg::ST_STEP: begin
        if (sts.w_zero && !sts.cap) begin
          state_nxt = mpool_pkg::ST_SCAN;
        end else if (sts.e_last) begin
          state_nxt = mpool_pkg::ST_IDLE;
        end
      end
      mpool_pkg::ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = mpool_pkg::ST_DRAIN;
        end
      end
      mpool_pkg::ST_DRAIN: begin
        state_nxt = mpool_pkg::ST_EMIT;
      end
      mpool_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = sts.e_last ? mpool_pkg::ST_IDLE : mpool_pkg::ST_STEP;
        end
      end
      default: begin
        state_nxt = mpool_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      mpool_pkg::ST_IDLE: begin
        // hold requests off while reset is applied
        in_stall   = !rst_n;
        cmd.accept = in_valid && rst_n;
      end
      mpool_pkg::ST_STEP: begin
        if (sts.w_zero && !sts.cap) begin
          cmd.win_start = 1'b1;
        end else begin
          // no window here, or result budget used up: still advance the phase
          cmd.e_done = 1'b1;
          cmd.fired  = sts.w_zero;
          cmd.finish = sts.e_last;
        end
      end
      mpool_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      mpool_pkg::ST_DRAIN: begin
        cmd = '0;
      end
      mpool_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          cmd.e_done    = 1'b1;
          cmd.fired     = 1'b1;
          cmd.finish    = sts.e_last;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mpool_dp.sv
// Datapath: configuration, row and ring state, history memory, window maximum, result register.
`default_nettype none

module mpool_dp #(
  parameter int MAX_WINDOW   = mpool_pkg::MAX_WINDOW_DEF,
  parameter int MAX_CHANNELS = mpool_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [mpool_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mpool_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire mpool_pkg::in_item_t               in_data,
  input  wire mpool_pkg::ctl_cmd_t               cmd,
  output      mpool_pkg::ctl_sts_t               sts,
  input  wire logic                              out_stall,
  output      logic                              out_valid,
  output      mpool_pkg::out_item_t              out_data
);

  localparam int SB     = mpool_pkg::SAMPLE_BITS;
  localparam int ROW_W  = mpool_pkg::ROW_W;
  localparam int E_W    = mpool_pkg::E_W;
  localparam int N_W    = mpool_pkg::N_W;
  localparam int STEP_W = mpool_pkg::STEP_W;
  localparam int KW     = $clog2(MAX_WINDOW + 1);
  localparam int RP_W   = $clog2(MAX_WINDOW);
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NCH_W  = $clog2(MAX_CHANNELS + 1);
  localparam int ADDR_W = $clog2(MAX_CHANNELS * MAX_WINDOW);
  // wide enough for window_size-1 and for any step code minus one
  localparam int WAIT_W = (RP_W > STEP_W) ? RP_W : STEP_W;
  localparam int BACK_W = ((KW > 5) ? KW : 5) + 2;

  localparam logic signed [SB-1:0] MIN_SAMPLE = {1'b1, {(SB-1){1'b0}}};

  // Configuration registers.
  logic [mpool_pkg::WSIZE_W-1:0]   win_size_r;
  logic [STEP_W-1:0]               step_r;
  logic [mpool_pkg::PAD_W-1:0]     pad_r;
  logic [mpool_pkg::NCH_CFG_W-1:0] nch_cfg_r;

  // Sequence state.
  logic [ROW_W-1:0]  row_counter_r, row_counter_nxt;
  logic [CH_W-1:0]   channel_counter_r, channel_counter_nxt;
  logic [RP_W-1:0]   ring_pos_r, ring_pos_nxt;
  logic [WAIT_W-1:0] wait_rows_r, wait_rows_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;

  // Per-request working state.
  logic                    row_end_r, row_end_nxt;
  logic                    seq_end_r, seq_end_nxt;
  logic signed [E_W-1:0]   e_r, e_nxt;
  logic [WAIT_W-1:0]       w_r, w_nxt;
  logic [ROW_W-1:0]        orow_r, orow_nxt;
  logic [WAIT_W-1:0]       w_keep_r, w_keep_nxt;
  logic [ROW_W-1:0]        orow_keep_r, orow_keep_nxt;
  logic [N_W-1:0]          n_r, n_nxt;
  logic [KW-1:0]           i_r, i_nxt;
  logic signed [SB-1:0]    max_r, max_nxt;
  logic                    rd_pend_r;

  logic                    out_valid_r, out_valid_nxt;
  mpool_pkg::out_item_t    out_data_r, out_data_nxt;

  // Effective configuration.
  logic [KW-1:0]     k_eff;
  logic [STEP_W-1:0] s_eff;
  logic [NCH_W-1:0]  nch_eff;

  always_comb begin
    if (win_size_r == '0) begin
      k_eff = KW'(1);
    end else if (32'(win_size_r) > 32'(MAX_WINDOW)) begin
      k_eff = KW'(MAX_WINDOW);
    end else begin
      k_eff = KW'(win_size_r);
    end
    s_eff = (step_r == '0) ? STEP_W'(1) : step_r;
    if (nch_cfg_r == '0) begin
      nch_eff = NCH_W'(1);
    end else if (32'(nch_cfg_r) > 32'(MAX_CHANNELS)) begin
      nch_eff = NCH_W'(MAX_CHANNELS);
    end else begin
      nch_eff = NCH_W'(nch_cfg_r);
    end
  end

  logic signed [E_W-1:0] pad_s;
  logic signed [E_W-1:0] e_hi;
  logic                  first_row;

  assign pad_s     = signed'(E_W'(pad_r));
  assign e_hi      = seq_end_r ? pad_s : '0;
  assign first_row = (row_counter_r == '0);

  // History addressing: one ring of MAX_WINDOW rows per channel.
  logic signed [BACK_W-1:0] back_s;
  logic [BACK_W-2:0]        back_u;
  logic                     back_ok;
  logic [RP_W:0]            idx_sum;
  logic [RP_W-1:0]          rd_idx;
  logic [ADDR_W-1:0]        wr_addr;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     rd_en;
  logic [SB-1:0]            rd_data;

  assign back_s  = signed'(BACK_W'(i_r)) - BACK_W'(e_r);
  assign back_u  = back_s[BACK_W-2:0];
  assign back_ok = !back_s[BACK_W-1]
                   && (32'(back_u) <= 32'(row_counter_r))
                   && (32'(back_u) < 32'(MAX_WINDOW));
  assign idx_sum = (RP_W+1)'(ring_pos_r) + (RP_W+1)'(MAX_WINDOW) - (RP_W+1)'(back_u);
  assign rd_idx  = (idx_sum >= (RP_W+1)'(MAX_WINDOW))
                   ? RP_W'(idx_sum - (RP_W+1)'(MAX_WINDOW)) : RP_W'(idx_sum);
  assign wr_addr = ADDR_W'(channel_counter_r) * ADDR_W'(MAX_WINDOW) + ADDR_W'(ring_pos_r);
  assign rd_addr = ADDR_W'(channel_counter_r) * ADDR_W'(MAX_WINDOW) + ADDR_W'(rd_idx);
  assign rd_en   = cmd.scan && back_ok;

  mpool_ram #(
    .WIDTH (SB),
    .DEPTH (MAX_CHANNELS * MAX_WINDOW)
  ) u_hist (
    .clk     (clk),
    .wr_en   (cmd.accept),
    .wr_addr (wr_addr),
    .wr_data (in_data.sample),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Window position bookkeeping.
  logic [WAIT_W-1:0]      w_upd;
  logic [ROW_W-1:0]       orow_upd;
  logic [WAIT_W-1:0]      w_keep_eff;
  logic [ROW_W-1:0]       orow_keep_eff;
  logic                   e_is_zero;
  logic                   row_close;
  logic signed [E_W:0]    e_left;
  logic                   last_window;

  assign e_is_zero = (e_r == '0);
  assign w_upd     = cmd.fired ? WAIT_W'(s_eff - STEP_W'(1)) : (w_r - WAIT_W'(1));
  assign orow_upd  = (cmd.fired && (orow_r != '1)) ? (orow_r + ROW_W'(1)) : orow_r;
  assign w_keep_eff    = e_is_zero ? w_upd : w_keep_r;
  assign orow_keep_eff = e_is_zero ? orow_upd : orow_keep_r;
  assign row_close = row_end_r
                     || ((NCH_W+1)'(channel_counter_r) + (NCH_W+1)'(1) >= (NCH_W+1)'(nch_eff));
  // another window ends in the remaining positions only if at least a full step remains
  assign e_left      = (E_W+1)'(e_hi) - (E_W+1)'(e_r);
  assign last_window = (n_r == N_W'(mpool_pkg::MAX_RESULTS - 1))
                       || (E_W'(e_left) < E_W'(s_eff));

  always_comb begin
    row_counter_nxt     = row_counter_r;
    channel_counter_nxt = channel_counter_r;
    ring_pos_nxt        = ring_pos_r;
    wait_rows_nxt       = wait_rows_r;
    out_row_nxt         = out_row_r;
    row_end_nxt         = row_end_r;
    seq_end_nxt         = seq_end_r;
    e_nxt               = e_r;
    w_nxt               = w_r;
    orow_nxt            = orow_r;
    w_keep_nxt          = w_keep_r;
    orow_keep_nxt       = orow_keep_r;
    n_nxt               = n_r;
    i_nxt               = i_r;
    max_nxt             = max_r;
    out_data_nxt        = out_data_r;
    out_valid_nxt       = out_valid_r && out_stall;

    if (cmd.accept) begin
      row_end_nxt = in_data.row_end;
      seq_end_nxt = in_data.sequence_end;
      n_nxt       = '0;
      orow_nxt    = out_row_r;
      e_nxt       = first_row ? -pad_s : '0;
      w_nxt       = first_row ? WAIT_W'(k_eff - KW'(1)) : wait_rows_r;
    end

    if (cmd.win_start) begin
      i_nxt   = '0;
      max_nxt = MIN_SAMPLE;
    end
    if (cmd.scan) begin
      i_nxt = i_r + KW'(1);
    end
    if (rd_pend_r && (signed'(rd_data) > max_r)) begin
      max_nxt = signed'(rd_data);
    end

    if (cmd.emit_load) begin
      out_valid_nxt                  = 1'b1;
      out_data_nxt.pooled            = max_r;
      out_data_nxt.out_row_index     = orow_r;
      out_data_nxt.out_channel_index = mpool_pkg::CHAN_OUT_W'(channel_counter_r);
      out_data_nxt.run_last          = last_window;
      n_nxt                          = n_r + N_W'(1);
    end

    if (cmd.e_done) begin
      w_nxt         = w_upd;
      orow_nxt      = orow_upd;
      w_keep_nxt    = w_keep_eff;
      orow_keep_nxt = orow_keep_eff;
      e_nxt         = e_r + E_W'(1);
    end

    if (cmd.finish) begin
      if (row_close) begin
        channel_counter_nxt = '0;
        if (seq_end_r) begin
          row_counter_nxt = '0;
          ring_pos_nxt    = '0;
          wait_rows_nxt   = '0;
          out_row_nxt     = '0;
        end else begin
          if (row_counter_r != '1) begin
            row_counter_nxt = row_counter_r + ROW_W'(1);
          end
          ring_pos_nxt  = (32'(ring_pos_r) == MAX_WINDOW - 1) ? '0 : ring_pos_r + RP_W'(1);
          wait_rows_nxt = w_keep_eff;
          out_row_nxt   = orow_keep_eff;
        end
      end else begin
        channel_counter_nxt = channel_counter_r + CH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r        <= mpool_pkg::WSIZE_W'(1);
      step_r            <= STEP_W'(1);
      pad_r             <= '0;
      nch_cfg_r         <= mpool_pkg::NCH_CFG_W'(1);
      row_counter_r     <= '0;
      channel_counter_r <= '0;
      ring_pos_r        <= '0;
      wait_rows_r       <= '0;
      out_row_r         <= '0;
      out_valid_r       <= 1'b0;
      rd_pend_r         <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          mpool_pkg::REG_WINDOW_SIZE:   win_size_r <= cfg_wdata[mpool_pkg::WSIZE_W-1:0];
          mpool_pkg::REG_STEP_ROWS:     step_r     <= cfg_wdata[STEP_W-1:0];
          mpool_pkg::REG_PAD_ROWS:      pad_r      <= cfg_wdata[mpool_pkg::PAD_W-1:0];
          mpool_pkg::REG_CHANNEL_COUNT: nch_cfg_r  <= cfg_wdata[mpool_pkg::NCH_CFG_W-1:0];
          default: begin
          end
        endcase
      end
      row_counter_r     <= row_counter_nxt;
      channel_counter_r <= channel_counter_nxt;
      ring_pos_r        <= ring_pos_nxt;
      wait_rows_r       <= wait_rows_nxt;
      out_row_r         <= out_row_nxt;
      out_valid_r       <= out_valid_nxt;
      rd_pend_r         <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    row_end_r   <= row_end_nxt;
    seq_end_r   <= seq_end_nxt;
    e_r         <= e_nxt;
    w_r         <= w_nxt;
    orow_r      <= orow_nxt;
    w_keep_r    <= w_keep_nxt;
    orow_keep_r <= orow_keep_nxt;
    n_r         <= n_nxt;
    i_r         <= i_nxt;
    max_r       <= max_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign sts.w_zero    = (w_r == '0);
  assign sts.cap       = (n_r == N_W'(mpool_pkg::MAX_RESULTS));
  assign sts.e_last    = (e_r == e_hi);
  assign sts.scan_last = (i_r == k_eff - KW'(1));
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/max_pool_1d_multichannel.sv
// Top level of the streaming multichannel 1-D max pooling block.
//
//   channel | ports                               | direction | request
//   --------+-------------------------------------+-----------+---------------------------------
//   input   | in_valid, in_stall, in_data         | in        | one sample of one channel
//   result  | out_valid, out_stall, out_data      | out       | one window maximum
//   config  | cfg_wr_en, cfg_index, cfg_wdata     | in        | one register write
//
// A request is taken and written into history in ST_IDLE, then each window position is checked
// in ST_STEP: one position on a middle row, up to 2*pad_rows+1 on the first or last row.
// Each window that ends is scanned in ST_SCAN: its rows are read one per cycle from the
// single read port of the history RAM, then ST_EMIT loads the maximum into the result reg.
// A new request is taken only once the previous one has finished; a result left waiting in the
// output register does not block that, but a later result holds until out_stall drops.
// Synchronous active-low reset presets config and clears row state; history needs no clearing.
`default_nettype none

module max_pool_1d_multichannel #(
  parameter int MAX_WINDOW   = mpool_pkg::MAX_WINDOW_DEF,
  parameter int MAX_CHANNELS = mpool_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration write port
  input  wire logic                            cfg_wr_en,
  input  wire logic [mpool_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mpool_pkg::CFG_W-1:0]     cfg_wdata,
  // sample stream
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire mpool_pkg::in_item_t             in_data,
  // pooled results
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      mpool_pkg::out_item_t            out_data
);

  mpool_pkg::ctl_cmd_t cmd;
  mpool_pkg::ctl_sts_t sts;

  // Sequencer: take a request, walk window positions, scan rows, emit.
  mpool_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: per-channel history rings, window phase and the result register.
  mpool_dp #(
    .MAX_WINDOW   (MAX_WINDOW),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for the multichannel 1-D max pooling block: directed cases, then random streams.
`timescale 1ns / 1ps

module testbench;
  import mpool_pkg::*;

  // Each channel keeps this many rows of history in the block.
  localparam int HIST_DEPTH = 16;
  localparam int CH_LIMIT   = 256;
  localparam int MINV       = -32768;
  // Longest busy stretch of one request: take, 2*15+1 positions, 16 windows of 16 rows each.
  // Round it up to cover the cycles after the last result of a request.
  localparam int DRAIN_CYC  = 400;
  // Quiet cycles allowed before giving up: well above the drain pause plus the longest stall.
  localparam int QUIET_MAX  = 4000;
  localparam int RAND_ITEMS = 260;
  localparam int PRINT_CAP  = 30;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;

  max_pool_1d_multichannel u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Pooling predictor: its own copy of the history rings, the settings and the
  // row/channel bookkeeping. hist_set marks ring entries that hold a sample.
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] hist [CH_LIMIT][HIST_DEPTH];
  bit                            hist_set [CH_LIMIT][HIST_DEPTH];
  logic [WSIZE_W-1:0]            win_len;
  logic [STEP_W-1:0]             step_len;
  logic [PAD_W-1:0]              pad_len;
  logic [NCH_CFG_W-1:0]          ch_cnt;
  int                            rows_done;     // real rows closed in this sequence
  int                            ch_next;       // channel of the next sample
  int                            ring;          // ring slot of the current row
  int                            rows_to_fire;  // window positions until the next window ends
  int                            next_row;      // output row of the next window

  out_item_t pooled_exp [$];   // window maxima still owed by the block

  int  err_cnt    = 0;
  int  sent_cnt   = 0;
  int  rand_sent  = 0;
  int  got_cnt    = 0;
  int  phase_cnt  = 0;
  int  quiet_cnt  = 0;
  int  stall_left = 0;
  bit  idle_on    = 1'b1;

  task automatic clear_model();
    win_len      = 1;
    step_len     = 1;
    pad_len      = 0;
    ch_cnt       = 1;
    rows_done    = 0;
    ch_next      = 0;
    ring         = 0;
    rows_to_fire = 0;
    next_row     = 0;
    foreach (hist_set[c, r]) hist_set[c][r] = 1'b0;
  endtask

  function automatic int eff_window();
    int k;
    k = (win_len == 0) ? 1 : int'(win_len);
    return (k > HIST_DEPTH) ? HIST_DEPTH : k;
  endfunction

  function automatic int eff_channels();
    int n;
    n = (ch_cnt == 0) ? 1 : int'(ch_cnt);
    return (n > CH_LIMIT) ? CH_LIMIT : n;
  endfunction

  // Max over the window that ends e rows from the current one; padding rows and
  // rows before the sequence start count as the minimum value.
  function automatic int window_peak(int c, int e, int k);
    int m, o, idx, v;
    m = MINV;
    for (int i = 0; i < k; i++) begin
      o = e - i;
      if (o <= 0 && -o <= rows_done && -o < HIST_DEPTH) begin
        idx = (ring + HIST_DEPTH + o) % HIST_DEPTH;
        v   = hist[c][idx];
        if (v > m) m = v;
      end
    end
    return m;
  endfunction

  // Advance the predictor by one accepted request and queue what it owes.
  task automatic pool_step(input in_item_t it);
    int        k, s, p, nch, c, w, orow, w_keep, orow_keep, lo, hi;
    bit        first;
    out_item_t res;
    out_item_t batch [$];
    k         = eff_window();
    s         = (step_len == 0) ? 1 : int'(step_len);
    p         = pad_len;
    nch       = eff_channels();
    c         = ch_next;
    first     = (rows_done == 0);
    hist[c][ring]     = it.sample;
    hist_set[c][ring] = 1'b1;
    w         = first ? k - 1 : rows_to_fire;
    orow      = next_row;
    w_keep    = 0;
    orow_keep = 0;
    // Leading pad windows only on the first row, trailing ones only on a sequence end.
    lo        = first ? -p : 0;
    hi        = it.sequence_end ? p : 0;
    for (int e = lo; e <= hi; e++) begin
      if (w == 0) begin
        // Drop windows past the per-request cap, but keep counting rows.
        if (batch.size() < MAX_RESULTS) begin
          res.pooled            = window_peak(c, e, k);
          res.out_row_index     = orow;
          res.out_channel_index = c;
          res.run_last          = 1'b0;
          batch.push_back(res);
        end
        if (orow < 'hFFFF) orow++;
        w = s - 1;
      end else begin
        w--;
      end
      if (e == 0) begin
        w_keep    = w;
        orow_keep = orow;
      end
    end
    if (batch.size() > 0) batch[batch.size()-1].run_last = 1'b1;
    foreach (batch[i]) pooled_exp.push_back(batch[i]);

    if (it.row_end || c + 1 >= nch) begin
      ch_next = 0;
      if (it.sequence_end) begin
        rows_done    = 0;
        ring         = 0;
        rows_to_fire = 0;
        next_row     = 0;
      end else begin
        if (rows_done < 'hFFFF) rows_done++;
        ring         = (ring + 1) % HIST_DEPTH;
        rows_to_fire = w_keep;
        next_row     = orow_keep;
      end
    end else begin
      ch_next = c + 1;
    end
  endtask

  // A row cut short leaves the skipped channels with their older ring entries.
  // Allow it only where those entries hold a sample, so no later window reads
  // an entry that was never written.
  function automatic bit can_cut_row(int c);
    for (int ch = c + 1; ch < eff_channels(); ch++) begin
      if (!hist_set[ch][ring]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle gaps: mostly short, now and then long.
  // ---------------------------------------------------------------------------
  function automatic int pick_gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_gap();
    if (!idle_on || $urandom_range(0, 2) != 0) return 0;
    return pick_gap_len();
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return MINV;
      1:       return 32767;
      2:       return 0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  // Result side: hold out_stall for random stretches while idling is on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= pick_gap_len();
    end else begin
      out_stall  <= 1'b0;
    end
  end

  task automatic report_mismatch(input string msg);
    if (err_cnt < PRINT_CAP) $display("mismatch at %0t ns: %s", $time, msg);
    err_cnt++;
  endtask

  // Compare every accepted result with the oldest owed window maximum.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      got_cnt++;
      if (pooled_exp.size() == 0) begin
        report_mismatch($sformatf("unexpected result pooled=%0d row=%0d ch=%0d last=%0b",
                                  out_data.pooled, out_data.out_row_index,
                                  out_data.out_channel_index, out_data.run_last));
      end else begin
        want = pooled_exp.pop_front();
        if (out_data.pooled !== want.pooled)
          report_mismatch($sformatf("pooled %0d, want %0d (row %0d ch %0d)", out_data.pooled,
                                    want.pooled, want.out_row_index, want.out_channel_index));
        if (out_data.out_row_index !== want.out_row_index)
          report_mismatch($sformatf("out_row_index %0d, want %0d", out_data.out_row_index,
                                    want.out_row_index));
        if (out_data.out_channel_index !== want.out_channel_index)
          report_mismatch($sformatf("out_channel_index %0d, want %0d",
                                    out_data.out_channel_index, want.out_channel_index));
        if (out_data.run_last !== want.run_last)
          report_mismatch($sformatf("run_last %0b, want %0b (row %0d ch %0d)", out_data.run_last,
                                    want.run_last, want.out_row_index, want.out_channel_index));
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cnt <= 0;
    else quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= QUIET_MAX) begin
      $display("[max_pool_1d_multichannel] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Send one sample request: optional gap, then hold it until taken. Valid
  // stays high on return so back-to-back requests need no second assignment.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp, input bit re,
                             input bit se);
    in_item_t it;
    int       gap;
    it.sample       = smp;
    it.row_end      = re;
    it.sequence_end = se;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    pool_step(it);
    sent_cnt++;
  endtask

  // Drive one register write; the caller drops cfg_wr_en after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_W-1:0];
    @(posedge clk);
    case (idx)
      REG_WINDOW_SIZE:   win_len  = value[WSIZE_W-1:0];
      REG_STEP_ROWS:     step_len = value[STEP_W-1:0];
      REG_PAD_ROWS:      pad_len  = value[PAD_W-1:0];
      REG_CHANNEL_COUNT: ch_cnt   = value[NCH_CFG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input int k, input int s, input int p, input int n);
    write_reg(REG_WINDOW_SIZE, k);
    write_reg(REG_STEP_ROWS, s);
    write_reg(REG_PAD_ROWS, p);
    write_reg(REG_CHANNEL_COUNT, n);
    cfg_wr_en <= 1'b0;
  endtask

  // Drop valid, wait for every owed result, then let the block finish any
  // request that owes nothing before touching the registers.
  task automatic settle();
    in_valid <= 1'b0;
    while (pooled_exp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // One sequence of rows with random content. Mostly well formed: full rows,
  // sequence end on the closing sample. Now and then a stray row end or a
  // stray sequence end. Wide channel counts get one short row only.
  task automatic run_sequence();
    int rows, cap, nch, c;
    bit last_row, wraps, re, se, row_done;
    nch  = eff_channels();
    rows = (nch > 8) ? 1 :
           ($urandom_range(0, 4) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
    for (int r = 0; r < rows; r++) begin
      last_row = (r == rows - 1);
      cap      = ($urandom_range(0, 4) == 0) ? $urandom_range(1, nch) : nch;
      if (nch > 8) cap = $urandom_range(1, 6);
      row_done = 1'b0;
      while (!row_done) begin
        c     = ch_next;
        wraps = (c + 1 >= nch);
        re    = wraps ? 1'($urandom_range(0, 1)) : (c + 1 >= cap);
        if ($urandom_range(0, 14) == 0) re = 1'b1;
        se    = last_row && (re || wraps);
        if ($urandom_range(0, 14) == 0) se = 1'b1;
        if (re && !wraps && !se && !can_cut_row(c)) re = 1'b0;
        send_sample(rand_sample(), re, se);
        rand_sent++;
        row_done = re || wraps;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Settings straight out of reset: one channel, window 1, step 1, no padding.
  task automatic test_reset_settings();
    send_sample(MINV, 1'b1, 1'b0);
    send_sample(32767, 1'b0, 1'b0);
    send_sample(0, 1'b1, 1'b1);
    send_sample(-1, 1'b0, 1'b1);
    settle();
  endtask

  // Deep padding with window 1: a first row ends 16 windows, a one-row
  // sequence ends 31 and must be cut at the per-request cap.
  task automatic test_window_overflow();
    set_regs(1, 1, 15, 1);
    send_sample(rand_sample(), 1'b0, 1'b0);
    send_sample(rand_sample(), 1'b1, 1'b1);
    send_sample(rand_sample(), 1'b1, 1'b1);
    settle();
  endtask

  // Two channels: fill three rows, then a sequence whose first row ends after
  // channel 0 and whose last row carries sequence end on a mid-row sample.
  task automatic test_short_rows();
    set_regs(2, 1, 1, 2);
    for (int r = 0; r < 3; r++) begin
      send_sample(rand_sample(), 1'b0, 1'b0);
      send_sample(rand_sample(), 1'b1, r == 2);
    end
    send_sample(MINV, 1'b1, 1'b0);
    send_sample(32767, 1'b0, 1'b1);
    send_sample(rand_sample(), 1'b1, 1'b1);
    settle();
  endtask

  // Change window, step and padding while a sequence is open; the window
  // phase carries over. Window code 31 acts as the largest window.
  task automatic test_live_reconfig();
    set_regs(3, 2, 2, 1);
    repeat (3) send_sample(rand_sample(), 1'b1, 1'b0);
    settle();
    write_reg(REG_WINDOW_SIZE, 31);
    write_reg(REG_STEP_ROWS, 16);
    write_reg(REG_PAD_ROWS, 15);
    cfg_wr_en <= 1'b0;
    send_sample(rand_sample(), 1'b1, 1'b1);
    settle();
  endtask

  // Phases of random settings, each with a few random sequences. The first
  // two phases take the largest and smallest effective window, padding and channel count.
  task automatic test_random_streams();
    int k, s, p, n, phase_start;
    while (rand_sent < RAND_ITEMS) begin
      case (phase_cnt)
        0: begin
          k = 16; s = 16; p = 15; n = 256;
        end
        1: begin
          k = 1; s = 1; p = 0; n = 1;
        end
        default: begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: k = $urandom_range(1, 5);
            6, 7:             k = $urandom_range(6, 16);
            8:                k = 0;
            default:          k = $urandom_range(17, 31);
          endcase
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: s = $urandom_range(1, 4);
            7, 8:                s = $urandom_range(5, 16);
            default:             s = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 31);
          endcase
          p = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 15);
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: n = $urandom_range(1, 4);
            7:                   n = $urandom_range(5, 8);
            8:                   n = 0;
            default:             n = $urandom_range(9, 511);
          endcase
        end
      endcase
      // Some phases run with no idling on either side.
      idle_on = ($urandom_range(0, 3) != 0);
      set_regs(k, s, p, n);
      phase_start = rand_sent;
      while (rand_sent - phase_start < 30 && rand_sent < RAND_ITEMS) run_sequence();
      settle();
      phase_cnt++;
    end
    idle_on = 1'b1;
  endtask

  initial begin
    clear_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_settings();
    test_window_overflow();
    test_short_rows();
    test_live_reconfig();
    test_random_streams();

    $display("run covered %0d sample requests (%0d random) over %0d random setting phases",
             sent_cnt, rand_sent, phase_cnt);
    $display("checked %0d window maxima, %0d mismatches", got_cnt, err_cnt);
    if (err_cnt == 0) $display("[max_pool_1d_multichannel] OK");
    else $display("[max_pool_1d_multichannel] ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/mpool_pkg.sv
hw/rtl/mpool_ram.sv
hw/rtl/mpool_ctrl.sv
hw/rtl/mpool_dp.sv
hw/rtl/max_pool_1d_multichannel.sv
bench/testbench.sv
